### rtl/hrlp_pkg.sv
package hrlp_pkg;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_METHOD  = 3'd1,
        PH_PATH    = 3'd2,
        PH_QUERY   = 3'd3,
        PH_PROTO   = 3'd4,
        PH_VERSION = 3'd5,
        PH_LINEEND = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_NONE   = 2'd0,
        ROLE_METHOD = 2'd1,
        ROLE_PATH   = 2'd2,
        ROLE_QUERY  = 2'd3
    } role_t;

    typedef enum logic [1:0] {
        METHOD_UNKNOWN = 2'd0,
        METHOD_GET     = 2'd1,
        METHOD_POST    = 2'd2,
        METHOD_HEAD    = 2'd3
    } method_t;

    localparam logic [7:0]  CHAR_LF       = 8'h0a;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [7:0]  CHAR_QUESTION = 8'h3f;
    localparam logic [7:0]  CHAR_DOT      = 8'h2e;
    localparam logic [7:0]  CHAR_P        = 8'h50;
    localparam logic [23:0] WORD_GET      = 24'h474554;
    localparam logic [31:0] WORD_POST     = 32'h504f5354;
    localparam logic [31:0] WORD_HEAD     = 32'h48454144;
    localparam logic [23:0] TRIPLE_HTT    = 24'h485454;
    localparam logic [2:0]  LEN_MAX       = 3'd7;
    localparam logic [2:0]  LEN_HEAD      = 3'd4;
    localparam logic [2:0]  LEN_GET       = 3'd3;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] head;
        logic [2:0]  len;
        logic [23:0] recent;
    } state_t;

    typedef struct packed {
        logic [7:0] byte_out;
        role_t      byte_role;
        logic       method_valid;
        method_t    method_code;
        logic       line_done;
    } result_t;

endpackage

### rtl/hrlp_stream_if.sv
interface hrlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrlp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [1:0] byte_role;
    logic       method_valid;
    logic [1:0] method_code;
    logic       line_done;

    modport source (output valid, output byte_out, output byte_role,
                    output method_valid, output method_code, output line_done,
                    input ready);
    modport sink   (input valid, input byte_out, input byte_role,
                    input method_valid, input method_code, input line_done,
                    output ready);
endinterface

### rtl/hrlp_step.sv
module hrlp_step (
    input  hrlp_pkg::state_t  cur,
    input  logic [7:0]        data_byte,
    output hrlp_pkg::state_t  nxt,
    output hrlp_pkg::result_t res
);

    // place a method byte in the head word and bump the saturating count
    function automatic hrlp_pkg::state_t store_byte(hrlp_pkg::state_t s, logic [7:0] b);
        hrlp_pkg::state_t r;
        r = s;
        if (s.len < hrlp_pkg::LEN_HEAD)
        begin
            case (s.len[1:0])
                2'd0:    r.head[31:24] = s.head[31:24] | b;
                2'd1:    r.head[23:16] = s.head[23:16] | b;
                2'd2:    r.head[15:8]  = s.head[15:8]  | b;
                default: r.head[7:0]   = s.head[7:0]   | b;
            endcase
        end
        if (s.len < hrlp_pkg::LEN_MAX)
        begin
            r.len = s.len + 3'd1;
        end
        return r;
    endfunction

    function automatic hrlp_pkg::method_t classify(hrlp_pkg::state_t s);
        hrlp_pkg::method_t m;
        m = hrlp_pkg::METHOD_UNKNOWN;
        if (s.len == hrlp_pkg::LEN_GET && s.head[31:8] == hrlp_pkg::WORD_GET)
        begin
            m = hrlp_pkg::METHOD_GET;
        end
        else if (s.len == hrlp_pkg::LEN_HEAD && s.head == hrlp_pkg::WORD_POST)
        begin
            m = hrlp_pkg::METHOD_POST;
        end
        else if (s.len == hrlp_pkg::LEN_HEAD && s.head == hrlp_pkg::WORD_HEAD)
        begin
            m = hrlp_pkg::METHOD_HEAD;
        end
        return m;
    endfunction

    hrlp_pkg::state_t fresh;

    always_comb
    begin
        fresh       = cur;
        fresh.head  = '0;
        fresh.len   = '0;

        nxt              = cur;
        res.byte_out     = data_byte;
        res.byte_role    = hrlp_pkg::ROLE_NONE;
        res.method_valid = 1'b0;
        res.method_code  = hrlp_pkg::METHOD_UNKNOWN;
        res.line_done    = 1'b0;

        unique case (cur.phase)
            hrlp_pkg::PH_METHOD:
            begin
                if (data_byte == hrlp_pkg::CHAR_SPACE)
                begin
                    res.method_valid = 1'b1;
                    res.method_code  = classify(cur);
                    nxt.phase        = hrlp_pkg::PH_PATH;
                end
                else
                begin
                    res.byte_role = hrlp_pkg::ROLE_METHOD;
                    nxt           = store_byte(cur, data_byte);
                end
            end
            hrlp_pkg::PH_PATH:
            begin
                if (data_byte == hrlp_pkg::CHAR_QUESTION)
                begin
                    nxt.phase = hrlp_pkg::PH_QUERY;
                end
                else if (data_byte == hrlp_pkg::CHAR_SPACE)
                begin
                    nxt.phase = hrlp_pkg::PH_PROTO;
                end
                else
                begin
                    res.byte_role = hrlp_pkg::ROLE_PATH;
                end
            end
            hrlp_pkg::PH_QUERY:
            begin
                if (data_byte == hrlp_pkg::CHAR_SPACE)
                begin
                    nxt.phase = hrlp_pkg::PH_PROTO;
                end
                else
                begin
                    res.byte_role = hrlp_pkg::ROLE_QUERY;
                end
            end
            hrlp_pkg::PH_PROTO:
            begin
                if (data_byte == hrlp_pkg::CHAR_P && cur.recent == hrlp_pkg::TRIPLE_HTT)
                begin
                    nxt.phase = hrlp_pkg::PH_VERSION;
                end
            end
            hrlp_pkg::PH_VERSION:
            begin
                if (data_byte == hrlp_pkg::CHAR_DOT)
                begin
                    nxt.phase = hrlp_pkg::PH_LINEEND;
                end
            end
            hrlp_pkg::PH_LINEEND:
            begin
                if (data_byte == hrlp_pkg::CHAR_LF)
                begin
                    res.line_done = 1'b1;
                    nxt.phase     = hrlp_pkg::PH_START;
                end
            end
            default:
            begin
                // start, and the unused phase code: any byte opens a method
                res.byte_role = hrlp_pkg::ROLE_METHOD;
                nxt           = store_byte(fresh, data_byte);
                nxt.phase     = hrlp_pkg::PH_METHOD;
            end
        endcase

        nxt.recent = {cur.recent[15:0], data_byte};
    end

endmodule

### rtl/http_request_line_parser.sv
// HTTP request line parser. One byte of the request line is taken per request on
// req_in and one tagged result leaves on res_out for each byte, in order. The
// phase update and the method and protocol compares sit in short logic between
// the accepting handshake and the result register, so a new byte is accepted
// every cycle while res_out keeps up, and also while a finished result still
// waits, as long as it is taken in the same cycle. There is no configuration
// and no start-up sweep after reset.
module http_request_line_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    hrlp_byte_if.sink            req_in,
    hrlp_result_if.source        res_out
);

    hrlp_pkg::state_t  state_reg;
    hrlp_pkg::state_t  state_next;
    hrlp_pkg::result_t result_reg;
    hrlp_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              accept;

    // result register frees up when empty or drained this cycle
    assign req_in.ready = !out_valid_reg || res_out.ready;
    assign accept       = req_in.valid && req_in.ready;

    // per-byte phase step
    hrlp_step u_step (
        .cur       (state_reg),
        .data_byte (req_in.data_byte),
        .nxt       (state_next),
        .res       (result_next)
    );

    // parser state advances only with an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase  <= hrlp_pkg::PH_START;
            state_reg.head   <= '0;
            state_reg.len    <= '0;
            state_reg.recent <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.byte_out     = result_reg.byte_out;
    assign res_out.byte_role    = result_reg.byte_role;
    assign res_out.method_valid = result_reg.method_valid;
    assign res_out.method_code  = result_reg.method_code;
    assign res_out.line_done    = result_reg.line_done;

    // an accepted byte always leaves a result behind
    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted byte left no result");

    // the method end leaves the parser in the path phase
    a_method_to_path : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.method_valid) |->
        (state_reg.phase == hrlp_pkg::PH_PATH))
        else $error("method end without path phase");

    // line end sends the parser back to start
    a_done_to_start : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.line_done) |->
        (state_reg.phase == hrlp_pkg::PH_START))
        else $error("line end without start phase");

    // method code only shown on the method end, which is a delimiter
    a_code_only_on_end : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.method_code != hrlp_pkg::METHOD_UNKNOWN) |->
        (result_reg.method_valid && result_reg.byte_role == hrlp_pkg::ROLE_NONE))
        else $error("method code outside method end");

endmodule

### verif/tag_stream_check.sv
`timescale 1ns / 1ps

// watches both channels, predicts the tag of every accepted byte and compares
module tag_stream_check (
    input  logic   clk,
    input  logic   rst_n,
    hrlp_byte_if   req_mon,
    hrlp_result_if res_mon,
    output int     tag_errors,
    output int     tags_pending
);

    hrlp_pkg::phase_t  phase;
    logic [31:0]       head;
    logic [2:0]        head_len;
    logic [23:0]       last_three;
    hrlp_pkg::result_t tag_queue[$];
    hrlp_pkg::result_t fresh_tag;
    hrlp_pkg::result_t oldest_tag;

    // only the first four method bytes are kept, the count saturates
    task automatic note_method_char(input logic [7:0] b);
        int slot;
        slot = 3 - int'(head_len);
        if (head_len < hrlp_pkg::LEN_HEAD)
        begin
            head[8 * slot +: 8] = b;
        end
        if (head_len < hrlp_pkg::LEN_MAX)
        begin
            head_len = head_len + 3'd1;
        end
    endtask

    task automatic tag_byte(input logic [7:0] b, output hrlp_pkg::result_t r);
        r = '0;
        r.byte_out = b;
        r.byte_role = hrlp_pkg::ROLE_NONE;
        r.method_code = hrlp_pkg::METHOD_UNKNOWN;
        case (phase)
            hrlp_pkg::PH_METHOD:
            begin
                if (b == hrlp_pkg::CHAR_SPACE)
                begin
                    r.method_valid = 1'b1;
                    if (head_len == hrlp_pkg::LEN_GET && head[31:8] == hrlp_pkg::WORD_GET)
                    begin
                        r.method_code = hrlp_pkg::METHOD_GET;
                    end
                    else if (head_len == hrlp_pkg::LEN_HEAD && head == hrlp_pkg::WORD_POST)
                    begin
                        r.method_code = hrlp_pkg::METHOD_POST;
                    end
                    else if (head_len == hrlp_pkg::LEN_HEAD && head == hrlp_pkg::WORD_HEAD)
                    begin
                        r.method_code = hrlp_pkg::METHOD_HEAD;
                    end
                    phase = hrlp_pkg::PH_PATH;
                end
                else
                begin
                    r.byte_role = hrlp_pkg::ROLE_METHOD;
                    note_method_char(b);
                end
            end
            hrlp_pkg::PH_PATH:
            begin
                if (b == hrlp_pkg::CHAR_QUESTION)
                begin
                    phase = hrlp_pkg::PH_QUERY;
                end
                else if (b == hrlp_pkg::CHAR_SPACE)
                begin
                    phase = hrlp_pkg::PH_PROTO;
                end
                else
                begin
                    r.byte_role = hrlp_pkg::ROLE_PATH;
                end
            end
            hrlp_pkg::PH_QUERY:
            begin
                if (b == hrlp_pkg::CHAR_SPACE)
                begin
                    phase = hrlp_pkg::PH_PROTO;
                end
                else
                begin
                    r.byte_role = hrlp_pkg::ROLE_QUERY;
                end
            end
            hrlp_pkg::PH_PROTO:
            begin
                if (b == hrlp_pkg::CHAR_P && last_three == hrlp_pkg::TRIPLE_HTT)
                begin
                    phase = hrlp_pkg::PH_VERSION;
                end
            end
            hrlp_pkg::PH_VERSION:
            begin
                if (b == hrlp_pkg::CHAR_DOT)
                begin
                    phase = hrlp_pkg::PH_LINEEND;
                end
            end
            hrlp_pkg::PH_LINEEND:
            begin
                if (b == hrlp_pkg::CHAR_LF)
                begin
                    r.line_done = 1'b1;
                    phase = hrlp_pkg::PH_START;
                end
            end
            default:
            begin
                // any byte opens a new method, a space too
                head = '0;
                head_len = '0;
                r.byte_role = hrlp_pkg::ROLE_METHOD;
                note_method_char(b);
                phase = hrlp_pkg::PH_METHOD;
            end
        endcase
        last_three = {last_three[15:0], b};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = hrlp_pkg::PH_START;
            head = '0;
            head_len = '0;
            last_three = '0;
            tag_queue.delete();
            tag_errors = 0;
            tags_pending = 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
            begin
                tag_byte(req_mon.data_byte, fresh_tag);
                tag_queue.push_back(fresh_tag);
            end
            if (res_mon.valid && res_mon.ready)
            begin
                if (tag_queue.size() == 0)
                begin
                    tag_errors++;
                    if (tag_errors <= 10)
                    begin
                        $display("%0t: unexpected result byte %h role %0d", $realtime,
                                 res_mon.byte_out, res_mon.byte_role);
                    end
                end
                else
                begin
                    oldest_tag = tag_queue.pop_front();
                    if (res_mon.byte_out !== oldest_tag.byte_out
                        || res_mon.byte_role !== oldest_tag.byte_role
                        || res_mon.method_valid !== oldest_tag.method_valid
                        || res_mon.method_code !== oldest_tag.method_code
                        || res_mon.line_done !== oldest_tag.line_done)
                    begin
                        tag_errors++;
                        if (tag_errors <= 10)
                        begin
                            $display("%0t: expected byte %h role %0d mv %b code %0d done %b",
                                     $realtime, oldest_tag.byte_out, oldest_tag.byte_role,
                                     oldest_tag.method_valid, oldest_tag.method_code,
                                     oldest_tag.line_done);
                            $display("%0t: actual   byte %h role %0d mv %b code %0d done %b",
                                     $realtime, res_mon.byte_out, res_mon.byte_role,
                                     res_mon.method_valid, res_mon.method_code,
                                     res_mon.line_done);
                        end
                    end
                end
            end
            tags_pending = tag_queue.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // bytes not named in the package
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;

    logic clk = 1'b0;
    logic rst_n;
    int   tag_errors;
    int   tags_pending;

    hrlp_byte_if   req_ch ();
    hrlp_result_if res_ch ();

    http_request_line_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_in  (req_ch.sink),
        .res_out (res_ch.source)
    );

    tag_stream_check tag_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_mon      (req_ch),
        .res_mon      (res_ch),
        .tag_errors   (tag_errors),
        .tags_pending (tags_pending)
    );

    // the whole byte stream is built first, then fed request by request
    logic [7:0] request_bytes[$];
    int         burst_left = 0;

    // methods that look close to a known one but must come out unknown,
    // the last one long enough to saturate the length count
    string near_miss [0:9] = '{"GE", "GETS", "POS", "POSTS", "HEA", "HEADX",
                               "PUT", "DELETE", "OPTIONS", "PROPFIND"};
    // wrong case never matches
    string case_miss [0:3] = '{"get", "Post", "hEAD", "GeT"};
    // protocol words: the real one most often, plus variants, some of which leave the
    // parser waiting in the protocol phase until a later HTTP turns up
    string proto_words [0:7] = '{"HTTP", "HTTP", "HTTP", "HHTTP", "HTTX", "HTT",
                                 "xHTTP", "htTP"};
    // ordinary path and query characters, with H, T and P to build near-protocols
    string path_chars = "abcxyzHTP0129/._=&-";

    // 20 ns clock
    always #10 clk = ~clk;

    // receiver: changes its stall habit every so often, from always ready
    // through a fixed rotating pattern to mostly stalled
    int         stall_mode = 0;
    int         mode_left = 0;
    logic [7:0] stall_shift = 8'b1011_0010;
    logic       sink_ready = 1'b0;

    assign res_ch.ready = sink_ready;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(16, 160);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        stall_shift <= {stall_shift[0], stall_shift[7:1]};
        case (stall_mode)
            0: sink_ready <= 1'b1;
            1: sink_ready <= ($urandom_range(0, 3) != 0);
            2: sink_ready <= stall_shift[0];
            default: sink_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            request_bytes.push_back(s[i]);
        end
    endtask

    // plain characters, with a share of fully random bytes given in percent
    task automatic add_chars(input int count, input int wild_pct);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < wild_pct)
            begin
                request_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                request_bytes.push_back(path_chars[$urandom_range(0, path_chars.len() - 1)]);
            end
        end
    endtask

    // one request line, mostly well formed with random content, sometimes
    // broken at one of its phases, and now and then pure noise
    task automatic add_request_line();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            add_chars($urandom_range(1, 12), 100);
            return;
        end
        // method
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1: add_text("GET");
            2, 3: add_text("POST");
            4, 5: add_text("HEAD");
            6: add_text(near_miss[$urandom_range(0, 9)]);
            7: add_chars($urandom_range(1, 9), 0);
            8: add_chars($urandom_range(1, 6), 100);
            default: add_text(case_miss[$urandom_range(0, 3)]);
        endcase
        request_bytes.push_back(hrlp_pkg::CHAR_SPACE);
        // path and optional query
        if ($urandom_range(0, 3) != 0)
        begin
            request_bytes.push_back(CHAR_SLASH);
        end
        add_chars($urandom_range(0, 6), 10);
        if ($urandom_range(0, 9) < 4)
        begin
            request_bytes.push_back(hrlp_pkg::CHAR_QUESTION);
            add_chars($urandom_range(0, 6), 10);
        end
        if ($urandom_range(0, 9) != 0)
        begin
            request_bytes.push_back(hrlp_pkg::CHAR_SPACE);
        end
        // protocol word and version
        add_text(proto_words[$urandom_range(0, 7)]);
        add_text("/1");
        if ($urandom_range(0, 9) != 0)
        begin
            request_bytes.push_back(hrlp_pkg::CHAR_DOT);
        end
        add_text("1");
        // line end, with stray bytes before it at times
        if ($urandom_range(0, 4) == 0)
        begin
            request_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) < 7)
        begin
            request_bytes.push_back(CHAR_CR);
        end
        if ($urandom_range(0, 19) != 0)
        begin
            request_bytes.push_back(hrlp_pkg::CHAR_LF);
        end
    endtask

    // sender: bursts of random length, random gaps between them, and now
    // and then a long burst with no gap at all
    task automatic send_request(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 12);
        end
        req_ch.valid <= 1'b1;
        req_ch.data_byte <= b;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data_byte <= 8'h00;
        rst_n <= 1'b0;

        // directed: a GET with a query holding a single zero byte and a
        // carriage return before the line feed
        add_text("GET /?");
        request_bytes.push_back(8'h00);
        add_text(" HTTP.");
        request_bytes.push_back(CHAR_CR);
        request_bytes.push_back(hrlp_pkg::CHAR_LF);
        // directed: a space as first method byte giving a five byte method,
        // then an all-ones path byte
        request_bytes.push_back(hrlp_pkg::CHAR_SPACE);
        add_text("HEAD ");
        request_bytes.push_back(8'hff);
        add_text(" HTTP.");
        request_bytes.push_back(hrlp_pkg::CHAR_LF);

        // random lines up to the target byte count
        while (request_bytes.size() < 940)
        begin
            add_request_line();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (request_bytes[i])
        begin
            send_request(request_bytes[i]);
        end
        req_ch.valid <= 1'b0;

        // drain: sample on the falling edge, away from the checker's updates
        @(negedge clk);
        while (tags_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        if (tag_errors == 0)
        begin
            $display("http_request_line_parser verification clean");
        end
        else
        begin
            $display("http_request_line_parser verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("http_request_line_parser verification failed");
        $finish;
    end

endmodule
